[hdl/cc_pkg.sv]
`timescale 1ns / 1ps

package cc_pkg;

  localparam int unsigned Words = 16;
  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned CntW = $clog2(DoubleRounds);
  localparam int unsigned PcW = 4;
  localparam int unsigned NumCfg = 6;
  localparam int unsigned CfgIdxW = $clog2(NumCfg);

  localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_KEY01   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_KEY23   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_KEY45   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_KEY67   = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] REG_NONCE01 = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] REG_NONCE2  = CfgIdxW'(5);

  // rows of the 4x4 state
  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  // program addresses
  localparam logic [PcW-1:0] S_IDLE  = PcW'(0);
  localparam logic [PcW-1:0] S_LOAD  = PcW'(1);
  localparam logic [PcW-1:0] S_COL0  = PcW'(2);
  localparam logic [PcW-1:0] S_COL1  = PcW'(3);
  localparam logic [PcW-1:0] S_COL2  = PcW'(4);
  localparam logic [PcW-1:0] S_COL3  = PcW'(5);
  localparam logic [PcW-1:0] S_DIAG0 = PcW'(6);
  localparam logic [PcW-1:0] S_DIAG1 = PcW'(7);
  localparam logic [PcW-1:0] S_DIAG2 = PcW'(8);
  localparam logic [PcW-1:0] S_DIAG3 = PcW'(9);
  localparam logic [PcW-1:0] S_FINAL = PcW'(10);
  localparam logic [PcW-1:0] S_EMIT  = PcW'(11);

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ROUND,
    OP_FINAL,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ACCEPT,
    JC_LOOP,
    JC_OUT_FREE
  } jc_t;

  typedef struct packed {
    op_t            op;
    logic           diag;
    logic [1:0]     line;
    jc_t            cond;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic       in_ready;
    logic       load;
    logic       round;
    logic       diag;
    logic [1:0] line;
    logic       fin;
    logic       emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic idx0;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [31:0] block_counter;
    logic [3:0]  word_index;
    logic [31:0] message_word;
    logic        use_data;
    logic [2:0]  valid_bytes;
  } item_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce01;
    logic [31:0]      nonce2;
  } cfg_t;

  function automatic ucode_t uc(op_t op, logic diag, logic [1:0] line, jc_t cond,
                                logic [PcW-1:0] target);
    ucode_t w;
    w.op = op;
    w.diag = diag;
    w.line = line;
    w.cond = cond;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic ucode_t cc_rom(logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      S_IDLE:  w = uc(OP_IDLE,  1'b0, 2'd0, JC_ACCEPT,   S_EMIT);
      S_LOAD:  w = uc(OP_LOAD,  1'b0, 2'd0, JC_NEXT,     S_IDLE);
      S_COL0:  w = uc(OP_ROUND, 1'b0, 2'd0, JC_NEXT,     S_IDLE);
      S_COL1:  w = uc(OP_ROUND, 1'b0, 2'd1, JC_NEXT,     S_IDLE);
      S_COL2:  w = uc(OP_ROUND, 1'b0, 2'd2, JC_NEXT,     S_IDLE);
      S_COL3:  w = uc(OP_ROUND, 1'b0, 2'd3, JC_NEXT,     S_IDLE);
      S_DIAG0: w = uc(OP_ROUND, 1'b1, 2'd0, JC_NEXT,     S_IDLE);
      S_DIAG1: w = uc(OP_ROUND, 1'b1, 2'd1, JC_NEXT,     S_IDLE);
      S_DIAG2: w = uc(OP_ROUND, 1'b1, 2'd2, JC_NEXT,     S_IDLE);
      S_DIAG3: w = uc(OP_ROUND, 1'b1, 2'd3, JC_LOOP,     S_COL0);
      S_FINAL: w = uc(OP_FINAL, 1'b0, 2'd0, JC_NEXT,     S_IDLE);
      S_EMIT:  w = uc(OP_EMIT,  1'b0, 2'd0, JC_OUT_FREE, S_IDLE);
      default: w = uc(OP_IDLE,  1'b0, 2'd0, JC_NEXT,     S_IDLE);
    endcase
    return w;
  endfunction

  // state word of a lane and row; diagonal mode shifts the column by the row
  function automatic logic [3:0] lane_idx(logic [1:0] lane, logic [1:0] role, logic diag);
    logic [1:0] col;
    col = lane + (diag ? role : 2'd0);
    return {role, col};
  endfunction

  function automatic logic [31:0] rot_line(logic [31:0] v, logic [1:0] line);
    logic [31:0] r;
    unique case (line)
      2'd0: r = {v[15:0], v[31:16]};
      2'd1: r = {v[19:0], v[31:20]};
      2'd2: r = {v[23:0], v[31:24]};
      2'd3: r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[hdl/cc_useq.sv]
`timescale 1ns / 1ps

module cc_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  cc_pkg::stat_t   stat,
  output cc_pkg::ctrl_t   ctrl
);

  logic [cc_pkg::PcW-1:0]  pc_r, pc_nxt;
  logic [cc_pkg::CntW-1:0] cnt_r, cnt_nxt;
  cc_pkg::ucode_t          uw;

  assign uw = cc_pkg::cc_rom(pc_r);

  always_comb begin
    ctrl.in_ready = (uw.op == cc_pkg::OP_IDLE);
    ctrl.load     = (uw.op == cc_pkg::OP_LOAD);
    ctrl.round    = (uw.op == cc_pkg::OP_ROUND);
    ctrl.diag     = uw.diag;
    ctrl.line     = uw.line;
    ctrl.fin      = (uw.op == cc_pkg::OP_FINAL);
    ctrl.emit     = (uw.op == cc_pkg::OP_EMIT) && stat.out_free;
  end

  always_comb begin
    pc_nxt  = pc_r + 1'b1;
    cnt_nxt = cnt_r;
    if (uw.op == cc_pkg::OP_LOAD) begin
      cnt_nxt = cc_pkg::CntW'(cc_pkg::DoubleRounds - 1);
    end
    unique case (uw.cond)
      cc_pkg::JC_NEXT: begin
        pc_nxt = pc_r + 1'b1;
      end
      cc_pkg::JC_ACCEPT: begin
        // word 0 falls into the block computation, others go straight to output
        if (!stat.in_valid) begin
          pc_nxt = pc_r;
        end else if (stat.idx0) begin
          pc_nxt = pc_r + 1'b1;
        end else begin
          pc_nxt = uw.target;
        end
      end
      cc_pkg::JC_LOOP: begin
        if (cnt_r != '0) begin
          pc_nxt  = uw.target;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      cc_pkg::JC_OUT_FREE: begin
        pc_nxt = stat.out_free ? uw.target : pc_r;
      end
      default: pc_nxt = cc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= cc_pkg::S_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hdl/cc_datapath.sv]
`timescale 1ns / 1ps

module cc_datapath (
  input  logic          clk,
  input  cc_pkg::ctrl_t ctrl,
  input  cc_pkg::cfg_t  cfg,
  input  cc_pkg::item_t item,
  output logic [31:0]   result
);

  logic [31:0] work_r  [cc_pkg::Words];
  logic [31:0] work_nxt[cc_pkg::Words];
  logic [31:0] store_r [cc_pkg::Words];
  logic [31:0] init    [cc_pkg::Words];
  logic [3:0]  pi [4];
  logic [3:0]  qi [4];
  logic [3:0]  ri [4];
  logic [31:0] psum [4];
  logic [31:0] ks;
  logic [31:0] word;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init[i]         = cc_pkg::SIGMA[i];
      init[4 + 2 * i] = cfg.key[i][31:0];
      init[5 + 2 * i] = cfg.key[i][63:32];
    end
    init[12] = item.block_counter;
    init[13] = cfg.nonce01[31:0];
    init[14] = cfg.nonce01[63:32];
    init[15] = cfg.nonce2;
  end

  // one line of the quarter round on all four lanes:
  // even lines a += b, d ^= a; odd lines c += d, b ^= c
  always_comb begin
    work_nxt = work_r;
    for (int l = 0; l < 4; l++) begin
      pi[l] = cc_pkg::lane_idx(2'(l), ctrl.line[0] ? cc_pkg::ROLE_C : cc_pkg::ROLE_A,
                               ctrl.diag);
      qi[l] = cc_pkg::lane_idx(2'(l), ctrl.line[0] ? cc_pkg::ROLE_D : cc_pkg::ROLE_B,
                               ctrl.diag);
      ri[l] = cc_pkg::lane_idx(2'(l), ctrl.line[0] ? cc_pkg::ROLE_B : cc_pkg::ROLE_D,
                               ctrl.diag);
      psum[l] = work_r[pi[l]] + work_r[qi[l]];
      work_nxt[pi[l]] = psum[l];
      work_nxt[ri[l]] = cc_pkg::rot_line(work_r[ri[l]] ^ psum[l], ctrl.line);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work_r <= init;
    end else if (ctrl.round) begin
      work_r <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      for (int i = 0; i < cc_pkg::Words; i++) begin
        store_r[i] <= work_r[i] + init[i];
      end
    end
  end

  always_comb begin
    ks   = store_r[item.word_index];
    word = item.use_data ? (ks ^ item.message_word) : ks;
    // byte k survives when more than k bytes are valid
    for (int k = 0; k < 4; k++) begin
      result[8 * k +: 8] = (item.valid_bytes > 3'(k)) ? word[8 * k +: 8] : 8'h00;
    end
  end

endmodule

[hdl/chacha20_keystream_xor_core.sv]
`timescale 1ns / 1ps

// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: block_counter, word_index, message_word,
//         |     |                     |        valid_bytes; tuser: use_data
// out_    | out | out_tvalid/out_tready | tdata: output_word
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (64 bit)
//
// word index 0: accept, key/nonce load, 10 double rounds (one quarter-round
// line over four lanes per cycle), add-back, output.
// other words: accept, output; a new beat is taken only after the output step.
// rst_n is synchronous, active low; it clears the sequencer, output valid and cfg.
// a result waiting on out_tready does not stop the next input beat; it holds
// the sequencer at its output step until the register frees.

module chacha20_keystream_xor_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [31:0] block_counter, [35:32] word_index, [67:36] message_word,
  // [70:68] valid_bytes, [71] zero
  input  logic [71:0]                 in_tdata,
  // [0] use_data
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] output_word
  output logic [31:0]                 out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                 cfg_data
);

  cc_pkg::cfg_t  cfg_r;
  cc_pkg::item_t item_r;
  cc_pkg::ctrl_t ctrl;
  cc_pkg::stat_t stat;
  logic          out_tvalid_r;
  logic [31:0]   out_tdata_r;
  logic [31:0]   result;
  logic          in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = ctrl.in_ready;
  assign in_acc    = in_tvalid && in_tready;

  assign stat.in_valid = in_tvalid;
  assign stat.idx0     = (in_tdata[35:32] == 4'd0);
  assign stat.out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cc_pkg::REG_KEY01:   cfg_r.key[0]  <= cfg_data;
        cc_pkg::REG_KEY23:   cfg_r.key[1]  <= cfg_data;
        cc_pkg::REG_KEY45:   cfg_r.key[2]  <= cfg_data;
        cc_pkg::REG_KEY67:   cfg_r.key[3]  <= cfg_data;
        cc_pkg::REG_NONCE01: cfg_r.nonce01 <= cfg_data;
        cc_pkg::REG_NONCE2:  cfg_r.nonce2  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.block_counter <= in_tdata[31:0];
      item_r.word_index    <= in_tdata[35:32];
      item_r.message_word  <= in_tdata[67:36];
      item_r.valid_bytes   <= in_tdata[70:68];
      item_r.use_data      <= in_tuser;
    end
  end

  cc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  cc_datapath u_datapath (
    .clk    (clk),
    .ctrl   (ctrl),
    .cfg    (cfg_r),
    .item   (item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_tdata_r <= result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[verif/chacha20_keystream_xor_checker.sv]
`timescale 1ns / 1ps

module chacha20_keystream_xor_checker
  import cc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [71:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [31:0]        out_tdata,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 pending_words,
  output int                 fail_count
);

  typedef logic [15:0][31:0] block_t;

  localparam logic [3:0][31:0] CHACHA_SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  cfg_t           key_nonce;
  block_t         keystream;
  logic [31:0]    expected_words [$];
  logic [31:0]    want_word;
  int             mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter_round(block_t w, int a, int b, int c, int d);
    w[a] = w[a] + w[b];
    w[d] = rotl(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d];
    w[b] = rotl(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b];
    w[d] = rotl(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d];
    w[b] = rotl(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic block_t chacha_block(cfg_t regs, logic [31:0] counter);
    block_t init;
    block_t w;
    block_t ks;
    for (int i = 0; i < 4; i++) begin
      init[i] = CHACHA_SIGMA[i];
      init[4 + 2 * i] = regs.key[i][31:0];
      init[5 + 2 * i] = regs.key[i][63:32];
    end
    init[12] = counter;
    init[13] = regs.nonce01[31:0];
    init[14] = regs.nonce01[63:32];
    init[15] = regs.nonce2;
    w = init;
    for (int r = 0; r < 10; r++) begin
      w = quarter_round(w, 0, 4, 8, 12);
      w = quarter_round(w, 1, 5, 9, 13);
      w = quarter_round(w, 2, 6, 10, 14);
      w = quarter_round(w, 3, 7, 11, 15);
      w = quarter_round(w, 0, 5, 10, 15);
      w = quarter_round(w, 1, 6, 11, 12);
      w = quarter_round(w, 2, 7, 8, 13);
      w = quarter_round(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks[i] = w[i] + init[i];
    return ks;
  endfunction

  // word 0 refreshes the stored keystream; every word then reads it
  function automatic logic [31:0] predict_word(logic [71:0] beat, logic xor_en);
    logic [3:0]  idx;
    logic [2:0]  nbytes;
    logic [31:0] mask;
    logic [31:0] word;
    idx = beat[35:32];
    if (idx == 4'd0) keystream = chacha_block(key_nonce, beat[31:0]);
    nbytes = (beat[70:68] > 3'd4) ? 3'd4 : beat[70:68];
    mask = (nbytes == 3'd4) ? 32'hffffffff : ((32'h1 << (8 * nbytes)) - 32'h1);
    word = keystream[idx];
    if (xor_en) word = word ^ beat[67:36];
    return word & mask;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_nonce = '0;
      keystream = '0;
      expected_words.delete();
      pending_words <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY01:   key_nonce.key[0] = cfg_data;
          REG_KEY23:   key_nonce.key[1] = cfg_data;
          REG_KEY45:   key_nonce.key[2] = cfg_data;
          REG_KEY67:   key_nonce.key[3] = cfg_data;
          REG_NONCE01: key_nonce.nonce01 = cfg_data;
          REG_NONCE2:  key_nonce.nonce2 = cfg_data[31:0];
          default: ;
        endcase
      end
      // output first: a beat taken now cannot already have its result
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("output beat with nothing expected", out_tdata, 32'h0);
        end else begin
          want_word = expected_words.pop_front();
          if (out_tdata !== want_word)
            report_mismatch("output_word", out_tdata, want_word);
        end
      end
      if (in_tvalid && in_tready)
        expected_words.push_back(predict_word(in_tdata, in_tuser));
      pending_words <= expected_words.size();
    end
  end

endmodule

[verif/chacha20_keystream_xor_core_tb.sv]
`timescale 1ns / 1ps

module chacha20_keystream_xor_core_tb;
  import cc_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 100;
  localparam int PhaseWords = 500;
  localparam logic [CfgIdxW-1:0] REG_NONE_LO = CfgIdxW'(NumCfg);
  localparam logic [CfgIdxW-1:0] REG_NONE_HI = CfgIdxW'(NumCfg + 1);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [71:0]        in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  int          pending_words;
  int          fail_count;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  logic [31:0] next_counter = '0;
  cfg_t        rfc_cfg;
  cfg_t        ones_cfg;
  cfg_t        phase_cfg;
  int          phase_start;
  bit          paused;

  chacha20_keystream_xor_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  chacha20_keystream_xor_checker keystream_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_words (pending_words),
    .fail_count    (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[chacha20_keystream_xor_core] ERROR");
    $finish;
  end

  // called right after a rising edge; returns at the edge that took the beat
  task automatic send_word(logic [31:0] ctr, logic [3:0] idx, logic [31:0] msg,
                           logic xor_en, logic [2:0] nbytes);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, nbytes, msg, idx, ctr};
    in_tuser  <= xor_en;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic cfg_put(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // caller lowers cfg_valid once the sequence is done
  task automatic load_config(cfg_t c);
    cfg_put(REG_KEY01, c.key[0]);
    cfg_put(REG_KEY23, c.key[1]);
    cfg_put(REG_KEY45, c.key[2]);
    cfg_put(REG_KEY67, c.key[3]);
    cfg_put(REG_NONCE01, c.nonce01);
    // upper half is junk that the block must drop
    cfg_put(REG_NONCE2, {32'($urandom), c.nonce2});
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_block();
    int unsigned len;
    logic [31:0] ctr;
    logic [2:0]  nbytes;
    if ($urandom_range(0, 9) == 0) begin
      // scattered beats, odd byte counts, mixed use_data
      repeat ($urandom_range(1, 8))
        send_word($urandom, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    end else begin
      len = $urandom_range(1, 16);
      ctr = ($urandom_range(0, 3) == 0) ? 32'($urandom) : next_counter;
      next_counter = ctr + 32'd1;
      for (int i = 0; i < len; i++) begin
        nbytes = (i == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4;
        send_word(ctr, 4'(i), $urandom, ($urandom_range(0, 7) != 0), nbytes);
      end
    end
  endtask

  initial begin
    rfc_cfg.key[0]  = {32'h07060504, 32'h03020100};
    rfc_cfg.key[1]  = {32'h0f0e0d0c, 32'h0b0a0908};
    rfc_cfg.key[2]  = {32'h17161514, 32'h13121110};
    rfc_cfg.key[3]  = {32'h1f1e1d1c, 32'h1b1a1918};
    rfc_cfg.nonce01 = {32'h4a000000, 32'h09000000};
    rfc_cfg.nonce2  = 32'h0;
    ones_cfg = '1;

    tx_idle_pct = 35;
    rx_idle_pct <= 73;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset key and nonce
    send_word(32'h0, 4'd0, 32'h0, 1'b0, 3'd4);
    send_word(32'h0, 4'd15, 32'hffffffff, 1'b1, 3'd4);
    send_word(32'h0, 4'd8, 32'hffffffff, 1'b1, 3'd0);
    wait_idle();

    load_config(rfc_cfg);
    cfg_put(REG_NONE_LO, '1);
    cfg_put(REG_NONE_HI, '1);
    cfg_valid <= 1'b0;
    send_word(32'd1, 4'd0, 32'h0, 1'b1, 3'd4);
    send_word(32'h0, 4'd1, $urandom, 1'b1, 3'd0);
    send_word(32'h0, 4'd2, $urandom, 1'b1, 3'd1);
    send_word(32'h0, 4'd3, $urandom, 1'b1, 3'd2);
    send_word(32'h0, 4'd4, $urandom, 1'b1, 3'd3);
    send_word(32'h0, 4'd5, $urandom, 1'b1, 3'd5);
    send_word(32'h0, 4'd6, $urandom, 1'b1, 3'd7);
    send_word(32'h0, 4'd7, 32'hffffffff, 1'b0, 3'd6);
    send_word(32'h0, 4'd15, 32'hffffffff, 1'b1, 3'd4);
    send_word(32'hffffffff, 4'd0, 32'hffffffff, 1'b1, 3'd4);
    // counter of a later word is ignored
    send_word(32'h12345678, 4'd9, $urandom, 1'b1, 3'd4);
    send_word(32'h0, 4'd0, 32'h0, 1'b0, 3'd4);
    send_word(32'h2, 4'd0, $urandom, 1'b1, 3'd4);
    send_word(32'h0, 4'd14, $urandom, 1'b1, 3'd4);
    wait_idle();

    load_config(ones_cfg);
    cfg_valid <= 1'b0;
    send_word(32'hffffffff, 4'd0, 32'h0, 1'b0, 3'd4);
    send_word(32'hffffffff, 4'd15, 32'h0, 1'b0, 3'd4);
    send_word(32'h0, 4'd1, 32'h0, 1'b1, 3'd4);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 35; rx_idle_pct <= 73; end
        1: begin tx_idle_pct = 73; rx_idle_pct <= 35; end
        default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
      endcase
      for (int i = 0; i < 4; i++) phase_cfg.key[i] = {32'($urandom), 32'($urandom)};
      phase_cfg.nonce01 = {32'($urandom), 32'($urandom)};
      phase_cfg.nonce2  = $urandom;
      if (phase == 2) phase_cfg = '0;
      load_config(phase_cfg);
      cfg_valid <= 1'b0;
      phase_start = words_sent;
      paused = 1'b0;
      // first beat of a phase always opens a block
      send_word($urandom, 4'd0, $urandom, 1'b1, 3'd4);
      while (words_sent - phase_start < PhaseWords) begin
        send_block();
        if (!paused && words_sent - phase_start >= PhaseWords / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("[chacha20_keystream_xor_core] OK");
    end else begin
      $display("[chacha20_keystream_xor_core] ERROR");
    end
    $finish;
  end

endmodule
